>>> design/swa_pkg.sv
// Shared constants and types for the sliding window average block.
// No dependencies; imported by every module of the block but swa_ram.

package swa_pkg;

    localparam int RING_DEPTH     = 64;
    localparam int SAMPLE_BITS    = 16;
    localparam int PTR_BITS       = $clog2(RING_DEPTH);
    localparam int FILL_BITS      = $clog2(RING_DEPTH + 1);
    localparam int SUM_BITS       = SAMPLE_BITS + PTR_BITS + 1;
    localparam int FRAC_BITS      = 8;
    localparam int AVG_BITS       = SAMPLE_BITS + FRAC_BITS;
    localparam int DIVD_BITS      = SUM_BITS + FRAC_BITS;
    localparam int WIN_BITS       = 7;
    localparam logic [WIN_BITS-1:0] WIN_RESET = 7'd4;

    localparam int DIV_RADIX_BITS = 4;
    localparam int DIV_STEPS      = AVG_BITS / DIV_RADIX_BITS;
    localparam int STEP_BITS      = $clog2(DIV_STEPS + 1);

    localparam int FIFO_DEPTH     = 2;
    localparam int FIFO_PTR_BITS  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_BITS  = $clog2(FIFO_DEPTH + 1);

    localparam int OUT_DATA_BITS  = ((AVG_BITS + FILL_BITS + 7) / 8) * 8;
    localparam int OUT_PAD_BITS   = OUT_DATA_BITS - AVG_BITS - FILL_BITS;

    typedef struct packed {
        logic signed [SUM_BITS-1:0] sum;
        logic [FILL_BITS-1:0]       fill;
    } t_avg_job;

endpackage

>>> design/sliding_window_average.sv
// Sliding window average top level: window size register, front end, job queue
// and divider back end. Depends on swa_pkg, swa_front, swa_fifo and swa_back.

// Each accepted sample gives one result: the mean of the last window_size samples
// (all samples since the last restart while fewer have arrived) in signed Q8,
// truncated toward zero, with the count that was averaged. A window size of zero
// acts as one and sizes above 64 act as 64; a smaller window takes full effect
// after a restart. The front end cannot take a new sample while one is in progress
// (it accepts, then makes the sum update once the ring read returns, and holds there
// while the job queue is full). The divider back end produces 4 quotient bits per
// cycle while dividing and takes the next job only once the last result has entered
// its output register. Write the window size only while no sample is in flight.

module sliding_window_average import swa_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [WIN_BITS-1:0]      i_cfg_wdata,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [SAMPLE_BITS-1:0]   s_axis_tdata,  // [15:0] sample
    input  logic                     s_axis_tuser,  // [0] restart
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [OUT_DATA_BITS-1:0] m_axis_tdata   // [23:0] average_q8, [30:24] fill_count
);

    logic [WIN_BITS-1:0]        r_win;
    logic                       push;
    t_avg_job                   push_job;
    logic                       full;
    logic                       pop;
    t_avg_job                   pop_job;
    logic                       empty;
    logic signed [AVG_BITS-1:0] average;
    logic [FILL_BITS-1:0]       fill;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= WIN_RESET;
        end else if (i_cfg_we) begin
            r_win <= i_cfg_wdata;
        end
    end

    swa_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_win     (r_win),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_sample  (s_axis_tdata),
        .i_restart (s_axis_tuser),
        .o_push    (push),
        .o_job     (push_job),
        .i_full    (full)
    );

    swa_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_job   (pop_job),
        .o_empty (empty)
    );

    swa_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_empty   (empty),
        .o_pop     (pop),
        .i_job     (pop_job),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_average (average),
        .o_fill    (fill)
    );

    assign m_axis_tdata = {{OUT_PAD_BITS{1'b0}}, fill, average};

endmodule

>>> design/swa_ram.sv
// Generic single write port, single read port RAM with registered read data.
// Read-first: a read and a write of the same address return the old entry.

module swa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> design/swa_front.sv
// Front end: accepts samples, keeps the sample ring, running sum and fill level,
// and pushes one sum and count job per sample. Depends on swa_pkg and swa_ram.

module swa_front import swa_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [WIN_BITS-1:0]           i_win,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic                          i_restart,
    output logic                          o_push,
    output t_avg_job                      o_job,
    input  logic                          i_full
);

    typedef enum logic {
        ST_IDLE,
        ST_UPDATE
    } t_front_state;

    t_front_state                r_state;
    logic signed [SUM_BITS-1:0]  r_sum;
    logic [FILL_BITS-1:0]        r_fill;
    logic [PTR_BITS-1:0]         r_wp;
    logic [PTR_BITS-1:0]         r_optr;
    logic signed [SAMPLE_BITS-1:0] r_sample;

    logic                        accept;
    logic [PTR_BITS-1:0]         wr_addr;
    logic [PTR_BITS-1:0]         rd_addr;
    logic signed [SAMPLE_BITS-1:0] oldest;
    logic [FILL_BITS-1:0]        eff_win;
    logic signed [SUM_BITS-1:0]  sum_add;
    logic [FILL_BITS-1:0]        fill_add;
    logic                        drop;
    logic signed [SUM_BITS-1:0]  n_sum;
    logic [FILL_BITS-1:0]        n_fill;

    function automatic logic [PTR_BITS-1:0] next_ptr(input logic [PTR_BITS-1:0] p);
        if (p == PTR_BITS'(RING_DEPTH - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    assign o_ready = (r_state == ST_IDLE);
    assign accept  = i_valid && o_ready;
    assign wr_addr = i_restart ? '0 : r_wp;
    assign rd_addr = i_restart ? '0 : r_optr;

    swa_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (accept),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_sample),
        .i_rd_en   (accept),
        .i_rd_addr (rd_addr),
        .o_rd_data (oldest)
    );

    always_comb begin
        if (i_win == '0) begin
            eff_win = FILL_BITS'(1);
        end else if ({1'b0, i_win} > (WIN_BITS + 1)'(RING_DEPTH)) begin
            eff_win = FILL_BITS'(RING_DEPTH);
        end else begin
            eff_win = FILL_BITS'(i_win);
        end
        sum_add  = r_sum + SUM_BITS'(r_sample);
        fill_add = r_fill + 1'b1;
        drop     = fill_add > eff_win;
        n_sum    = drop ? sum_add - SUM_BITS'(oldest) : sum_add;
        n_fill   = drop ? r_fill : fill_add;
    end

    assign o_push     = (r_state == ST_UPDATE) && !i_full;
    assign o_job.sum  = n_sum;
    assign o_job.fill = n_fill;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_sum   <= '0;
            r_fill  <= '0;
            r_wp    <= '0;
            r_optr  <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_sample <= i_sample;
                        r_wp     <= next_ptr(wr_addr);
                        r_state  <= ST_UPDATE;
                        if (i_restart) begin
                            r_sum  <= '0;
                            r_fill <= '0;
                            r_optr <= '0;
                        end
                    end
                end
                ST_UPDATE: begin
                    if (!i_full) begin
                        r_sum   <= n_sum;
                        r_fill  <= n_fill;
                        r_state <= ST_IDLE;
                        if (drop) begin
                            r_optr <= next_ptr(r_optr);
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    a_fill_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_BITS'(RING_DEPTH))
        else $error("fill level above ring depth");

    a_restart_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_restart) |=> (r_fill == '0 && r_sum == '0 && r_optr == '0))
        else $error("restart did not clear the window state");

    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (o_job.fill != '0))
        else $error("job pushed with an empty window");

endmodule

>>> design/swa_fifo.sv
// Short job queue between the front end and the divider back end.
// Depends on swa_pkg for the job type and depth.

module swa_fifo import swa_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_avg_job i_job,
    output logic     o_full,
    input  logic     i_pop,
    output t_avg_job o_job,
    output logic     o_empty
);

    t_avg_job                 r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0] r_wr_ptr;
    logic [FIFO_PTR_BITS-1:0] r_rd_ptr;
    logic [FIFO_CNT_BITS-1:0] r_count;

    function automatic logic [FIFO_PTR_BITS-1:0] next_ptr(
        input logic [FIFO_PTR_BITS-1:0] p
    );
        if (p == FIFO_PTR_BITS'(FIFO_DEPTH - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    assign o_full  = (r_count == FIFO_CNT_BITS'(FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_wr_ptr <= next_ptr(r_wr_ptr);
            end
            if (i_pop && !o_empty) begin
                r_rd_ptr <= next_ptr(r_rd_ptr);
            end
            case ({i_push && !o_full, i_pop && !o_empty})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> design/swa_back.sv
// Back end: divides each queued sum, scaled by 256, by its count, four quotient
// bits per cycle, and holds the result in an output register. Depends on swa_pkg.

module swa_back import swa_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_empty,
    output logic                       o_pop,
    input  t_avg_job                   i_job,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic signed [AVG_BITS-1:0] o_average,
    output logic [FILL_BITS-1:0]       o_fill
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } t_back_state;

    t_back_state                r_state;
    logic [FILL_BITS-1:0]       r_rem;
    logic [AVG_BITS-1:0]        r_work;
    logic [FILL_BITS-1:0]       r_div;
    logic                       r_neg;
    logic [STEP_BITS-1:0]       r_step;
    logic                       r_out_valid;
    logic signed [AVG_BITS-1:0] r_out_avg;
    logic [FILL_BITS-1:0]       r_out_fill;

    logic [SUM_BITS-1:0]        mag;
    logic [DIVD_BITS-1:0]       dividend;
    logic [FILL_BITS-1:0]       n_rem;
    logic [AVG_BITS-1:0]        n_work;
    logic                       load_out;

    assign o_pop    = (r_state == ST_IDLE) && !i_empty;
    assign load_out = (r_state == ST_DONE) && (!r_out_valid || i_ready);

    always_comb begin
        mag      = i_job.sum[SUM_BITS-1] ? SUM_BITS'(-i_job.sum) : SUM_BITS'(i_job.sum);
        dividend = {mag, {FRAC_BITS{1'b0}}};
    end

    always_comb begin
        logic [FILL_BITS:0]   v_trial;
        logic [FILL_BITS-1:0] v_rem;
        logic [AVG_BITS-1:0]  v_work;
        v_rem  = r_rem;
        v_work = r_work;
        for (int k = 0; k < DIV_RADIX_BITS; k++) begin
            v_trial = {v_rem, v_work[AVG_BITS-1]};
            v_work  = {v_work[AVG_BITS-2:0], 1'b0};
            if (v_trial >= {1'b0, r_div}) begin
                v_rem     = FILL_BITS'(v_trial - {1'b0, r_div});
                v_work[0] = 1'b1;
            end else begin
                v_rem = v_trial[FILL_BITS-1:0];
            end
        end
        n_rem  = v_rem;
        n_work = v_work;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load_out) begin
                r_out_valid <= 1'b1;
                r_out_avg   <= r_neg ? AVG_BITS'(-r_work) : AVG_BITS'(r_work);
                r_out_fill  <= r_div;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (!i_empty) begin
                        r_rem   <= FILL_BITS'(dividend[DIVD_BITS-1:AVG_BITS]);
                        r_work  <= dividend[AVG_BITS-1:0];
                        r_div   <= i_job.fill;
                        r_neg   <= i_job.sum[SUM_BITS-1];
                        r_step  <= '0;
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    r_rem  <= n_rem;
                    r_work <= n_work;
                    r_step <= r_step + 1'b1;
                    if (r_step == STEP_BITS'(DIV_STEPS - 1)) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (load_out) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_valid   = r_out_valid;
    assign o_average = r_out_avg;
    assign o_fill    = r_out_fill;

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_div != '0 && r_rem < r_div))
        else $error("divider running with a bad divisor or remainder");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |=> (r_out_valid && $stable(r_out_avg)))
        else $error("pending result overwritten");

endmodule

>>> dv/swa_mean_checker.sv
// Checker for the sliding window average: watches the register port and both
// stream channels, tracks the window state and compares every output transfer.
// Depends on swa_pkg for widths and the reset window size.

module swa_mean_checker import swa_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [WIN_BITS-1:0]      i_cfg_wdata,
    input  logic                     s_axis_tvalid,
    input  logic                     s_axis_tready,
    input  logic [SAMPLE_BITS-1:0]   s_axis_tdata,  // [15:0] sample
    input  logic                     s_axis_tuser,  // [0] restart
    input  logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    input  logic [OUT_DATA_BITS-1:0] m_axis_tdata,  // [23:0] average_q8, [30:24] fill_count
    output int                       o_fail_count,
    output int                       o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [AVG_BITS-1:0] avg_q8;
        logic [FILL_BITS-1:0]       fill;
    } t_mean;

    logic signed [SAMPLE_BITS-1:0] recent_samples [RING_DEPTH];
    logic [WIN_BITS-1:0]           window_reg;
    longint                        window_sum;
    int                            held;
    int                            wr_ptr;
    int                            old_ptr;
    int                            mismatches = 0;
    t_mean                         expected_means [$];

    assign o_fail_count = mismatches;

    function automatic t_mean track_sample(input logic signed [SAMPLE_BITS-1:0] smp,
                                           input logic restart);
        longint dropped;
        int     span;
        t_mean  m;
        span = (window_reg == 0) ? 1 : (window_reg > RING_DEPTH) ? RING_DEPTH : int'(window_reg);
        if (restart) begin
            window_sum = 0;
            held       = 0;
            wr_ptr     = 0;
            old_ptr    = 0;
        end
        dropped = recent_samples[old_ptr];
        recent_samples[wr_ptr] = smp;
        wr_ptr = (wr_ptr + 1) % RING_DEPTH;
        window_sum += smp;
        held++;
        if (held > span) begin
            window_sum -= dropped;
            held--;
            old_ptr = (old_ptr + 1) % RING_DEPTH;
        end
        m.avg_q8 = AVG_BITS'((window_sum * 256) / held);
        m.fill   = FILL_BITS'(held);
        return m;
    endfunction

    always @(posedge i_clk) begin
        t_mean want;
        if (!i_rst_n) begin
            window_reg = WIN_RESET;
            window_sum = 0;
            held       = 0;
            wr_ptr     = 0;
            old_ptr    = 0;
            expected_means.delete();
        end else begin
            if (i_cfg_we) begin
                window_reg = i_cfg_wdata;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                expected_means.insert(expected_means.size(),
                                      track_sample(s_axis_tdata, s_axis_tuser));
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_means.size() == 0) begin
                    $display("%0t: unexpected output transfer, data %h", $time, m_axis_tdata);
                    mismatches++;
                end else begin
                    want = expected_means.pop_front();
                    if (m_axis_tdata[AVG_BITS-1:0] !== want.avg_q8) begin
                        $display("%0t: average_q8 expected %0d, actual %0d", $time,
                                 want.avg_q8, $signed(m_axis_tdata[AVG_BITS-1:0]));
                        mismatches++;
                    end
                    if (m_axis_tdata[AVG_BITS +: FILL_BITS] !== want.fill) begin
                        $display("%0t: fill_count expected %0d, actual %0d", $time,
                                 want.fill, m_axis_tdata[AVG_BITS +: FILL_BITS]);
                        mismatches++;
                    end
                end
            end
        end
        o_outstanding <= expected_means.size();
    end

endmodule

>>> dv/tb_sliding_window_average.sv
// Top of the sliding window average testbench: clock, reset, window size writes,
// sample stimulus and output back-pressure, plus the final verdict.
// Depends on swa_pkg, the sliding_window_average block and swa_mean_checker.

module tb_sliding_window_average;
    timeunit 1ns;
    timeprecision 1ps;
    import swa_pkg::*;

    localparam int LIMIT_CYCLES = 500000;
    localparam int DRAIN_CYCLES = 30;
    localparam int RANDOM_ITEMS = 850;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_we = 1'b0;
    logic [WIN_BITS-1:0]      i_cfg_wdata = WIN_RESET;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [SAMPLE_BITS-1:0]   s_axis_tdata = '0;
    logic                     s_axis_tuser = 1'b0;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0] m_axis_tdata;

    int checker_failures;
    int checker_outstanding;
    int cycle_count = 0;
    bit steady_sender = 1'b0;

    always #2 i_clk = ~i_clk;

    sliding_window_average dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    swa_mean_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .o_fail_count  (checker_failures),
        .o_outstanding (checker_outstanding)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("sliding_window_average verification failed");
            $finish;
        end
    end

    function automatic int sender_gap();
        int r;
        if (steady_sender) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 94) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic int stall_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return $urandom_range(1, 2);
        end
        if (r < 92) begin
            return $urandom_range(3, 6);
        end
        return $urandom_range(15, 40);
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] pick_sample(input int style);
        case (style)
            1: begin
                return ($urandom_range(0, 7) == 0) ? SAMPLE_BITS'($urandom) : 16'h7fff;
            end
            2: begin
                return ($urandom_range(0, 7) == 0) ? SAMPLE_BITS'($urandom) : 16'h8000;
            end
            3: begin
                case ($urandom_range(0, 4))
                    0: return 16'h0000;
                    1: return 16'hffff;
                    2: return 16'h0001;
                    3: return 16'h7fff;
                    default: return 16'h8000;
                endcase
            end
            default: begin
                return SAMPLE_BITS'($urandom);
            end
        endcase
    endfunction

    task automatic send_sample(input logic [SAMPLE_BITS-1:0] smp, input logic restart);
        int gap;
        gap = sender_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= smp;
        s_axis_tuser  <= restart;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (checker_outstanding != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_window(input logic [WIN_BITS-1:0] size);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= size;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin
        int hold;
        forever begin
            hold = ($urandom_range(0, 99) < 15) ? $urandom_range(30, 120) : $urandom_range(1, 8);
            m_axis_tready <= 1'b1;
            repeat (hold) @(posedge i_clk);
            hold = stall_length();
            m_axis_tready <= 1'b0;
            repeat (hold) @(posedge i_clk);
        end
    end

    initial begin
        int                  sent;
        int                  phase_len;
        int                  style;
        logic [WIN_BITS-1:0] span;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset window of four: fill up at full scale, then swing to the other extreme.
        for (int k = 0; k < 6; k++) begin
            send_sample(16'h7fff, k == 0);
        end
        for (int k = 0; k < 6; k++) begin
            send_sample(16'h8000, 1'b0);
        end
        send_sample(16'h0000, 1'b1);
        send_sample(16'hffff, 1'b0);
        send_sample(16'h0001, 1'b0);

        // A zero window behaves as a window of one.
        write_window(7'd0);
        send_sample(16'h8000, 1'b1);
        send_sample(16'h7fff, 1'b0);
        send_sample(16'h0001, 1'b0);

        // Oversized window saturates and grows one sample per transfer.
        write_window(7'd127);
        for (int k = 0; k < 4; k++) begin
            send_sample(16'h8000, 1'b0);
        end

        // Shrinking without a restart drops at most one sample per transfer.
        write_window(7'd2);
        for (int k = 0; k < 3; k++) begin
            send_sample(pick_sample(0), 1'b0);
        end

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0: span = 7'd0;
                1: span = 7'd1;
                2: span = 7'd64;
                3: span = 7'd127;
                4: span = 7'd63;
                5: span = 7'd65;
                default: span = WIN_BITS'($urandom_range(2, 64));
            endcase
            write_window(span);
            steady_sender = ($urandom_range(0, 3) == 0);
            style = $urandom_range(0, 3);
            phase_len = $urandom_range(20, 140);
            if (phase_len > RANDOM_ITEMS - sent) begin
                phase_len = RANDOM_ITEMS - sent;
            end
            for (int k = 0; k < phase_len; k++) begin
                send_sample(pick_sample(style),
                            (k == 0 && $urandom_range(0, 1) == 1) || $urandom_range(0, 39) == 0);
            end
            sent += phase_len;
        end

        wait_drained();
        if (checker_failures == 0) begin
            $display("sliding_window_average verification clean");
        end else begin
            $display("sliding_window_average verification failed");
        end
        $finish;
    end

endmodule

>>> sim.f
design/swa_pkg.sv
design/swa_ram.sv
design/swa_front.sv
design/swa_fifo.sv
design/swa_back.sv
design/sliding_window_average.sv
dv/swa_mean_checker.sv
dv/tb_sliding_window_average.sv
